// File: rtl/light_attribute_color_engine_defines.svh
// Assertion macros shared by the checker of the light attribute color engine.
`ifndef LIGHT_ATTRIBUTE_COLOR_ENGINE_DEFINES_SVH
`define LIGHT_ATTRIBUTE_COLOR_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define LACE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lace check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define LACE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lace check failed");

`endif

// File: rtl/lace_pkg.sv
// Shared types and constants of the light attribute color engine.
package lace_pkg;

	localparam logic [2:0] CMD_ONOFF = 3'd0;
	localparam logic [2:0] CMD_LEVEL = 3'd1;
	localparam logic [2:0] CMD_HUE   = 3'd2;
	localparam logic [2:0] CMD_SAT   = 3'd3;
	localparam logic [2:0] CMD_X     = 3'd4;
	localparam logic [2:0] CMD_Y     = 3'd5;
	localparam logic [2:0] CMD_EHUE  = 3'd6;
	localparam logic [2:0] CMD_OTHER = 3'd7;

	localparam logic [7:0]  ENDPOINT_RESET = 8'd10;
	localparam logic [7:0]  SAT_RESET      = 8'd255;
	localparam logic [16:0] Q16_ONE        = 17'd65536;

	// sRGB matrix, Q2.15, row per output channel
	localparam logic signed [17:0] MTX [3][3] = '{
		'{ 18'sd106188, -18'sd50371, -18'sd16338 },
		'{ -18'sd31749,  18'sd61466,   18'sd1360 },
		'{   18'sd1825,  -18'sd6685,  18'sd34636 }
	};

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] attr_value;
		logic        value_present;
		logic [7:0]  endpoint;
		logic        status_ok;
		logic        type_ok;
	} in_word_t;

	typedef struct packed {
		logic       error;
		logic       power_valid;
		logic       power_on;
		logic       level_valid;
		logic [7:0] brightness;
		logic       color_valid;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} out_word_t;

	typedef enum logic [1:0] {
		OP_DIRECT = 2'd0,
		OP_HSV    = 2'd1,
		OP_XY     = 2'd2
	} op_t;

	typedef struct packed {
		op_t         op;
		out_word_t   res;
		logic [15:0] hue16;
		logic [7:0]  sat;
		logic [15:0] x;
		logic [15:0] y;
	} job_t;

endpackage

// File: rtl/lace_fifo.sv
// Small first-in first-out queue with full and empty flags.
module lace_fifo #(
	parameter int DEPTH = 2,
	parameter type T = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     din,
	output logic full,
	input  logic pop,
	output T     dout,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                 mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/lace_front.sv
// Front part: endpoint register, attribute stores and classification of each write.
module lace_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  lace_pkg::in_word_t req,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data,
	output lace_pkg::job_t    job
);

	logic [7:0]  endpoint_q;
	logic [7:0]  hue_q, sat_q;
	logic [15:0] x_q;
	logic [7:0]  hue_d, sat_d;
	logic [15:0] x_d;

	assign cfg_ready = 1'b1;

	always_comb begin
		job       = '0;
		job.op    = lace_pkg::OP_DIRECT;
		hue_d     = hue_q;
		sat_d     = sat_q;
		x_d       = x_q;
		if (!req.status_ok) begin
			job.res.error = 1'b1;
		end else if (req.endpoint == endpoint_q && req.type_ok) begin
			unique case (req.command)
				lace_pkg::CMD_ONOFF: begin
					job.res.power_valid = 1'b1;
					job.res.power_on    = req.value_present & req.attr_value[0];
				end
				lace_pkg::CMD_LEVEL: begin
					job.res.level_valid = 1'b1;
					job.res.brightness  = req.value_present ? req.attr_value[7:0] : 8'd255;
				end
				lace_pkg::CMD_HUE: begin
					hue_d     = req.value_present ? req.attr_value[7:0] : 8'd0;
					job.op    = lace_pkg::OP_HSV;
					job.hue16 = {hue_d, hue_d};
					job.sat   = sat_q;
				end
				lace_pkg::CMD_SAT: begin
					sat_d     = req.value_present ? req.attr_value[7:0] : 8'd255;
					job.op    = lace_pkg::OP_HSV;
					job.hue16 = {hue_q, hue_q};
					job.sat   = sat_d;
				end
				lace_pkg::CMD_X: begin
					x_d = req.value_present ? req.attr_value : 16'd0;
				end
				lace_pkg::CMD_Y: begin
					job.op = lace_pkg::OP_XY;
					job.x  = x_q;
					job.y  = req.value_present ? req.attr_value : 16'd0;
				end
				lace_pkg::CMD_EHUE: begin
					job.op    = lace_pkg::OP_HSV;
					job.hue16 = req.value_present ? req.attr_value : 16'd0;
					job.sat   = sat_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			endpoint_q <= lace_pkg::ENDPOINT_RESET;
			hue_q      <= '0;
			sat_q      <= lace_pkg::SAT_RESET;
			x_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				endpoint_q <= cfg_data;
			end
			if (accept) begin
				hue_q <= hue_d;
				sat_q <= sat_d;
				x_q   <= x_d;
			end
		end
	end

endmodule

// File: rtl/lace_back.sv
// Back part: HSV and CIE xy color sequencer with one shared multiplier and gamma ROM.
module lace_back #(
	parameter int ENTRIES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lace_pkg::job_t      job,
	input  logic                job_empty,
	output logic                job_pop,
	output lace_pkg::out_word_t res,
	output logic                res_push,
	input  logic                res_full
);

	localparam int IDX_W = $clog2(ENTRIES);

	typedef logic [7:0] gamma_rom_t [ENTRIES];

	function automatic gamma_rom_t build_gamma();
		gamma_rom_t        tab;
		longint unsigned   thr [256];
		longint unsigned   t, t2, lo, hi, mid, p, d, lim;
		int unsigned       n;
		thr[0] = 0;
		for (int c = 1; c < 256; c++) begin
			if (c <= 10) begin
				d = ((longint'(c) * 100) << 30) / 329460;
			end else begin
				t  = ((longint'(c) * 1000 + 14025) << 30) / 269025;
				t2 = (t * t) >> 30;
				lo = 0;
				hi = 64'd1 << 30;
				while (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					p   = mid;
					for (int k = 0; k < 4; k++) begin
						p = (p * mid) >> 30;
					end
					if (p <= t2) begin
						lo = mid;
					end else begin
						hi = mid - 1;
					end
				end
				d = (t2 * lo) >> 30;
			end
			thr[c] = d * longint'(ENTRIES - 1);
		end
		for (int i = 0; i < ENTRIES; i++) begin
			n   = 0;
			lim = longint'(i) << 30;
			for (int c = 1; c < 256; c++) begin
				if (thr[c] <= lim) begin
					n++;
				end
			end
			tab[i] = 8'(n);
		end
		return tab;
	endfunction

	localparam gamma_rom_t GAMMA_ROM = build_gamma();

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_DECODE  = 9'b000000010,
		ST_HSV_MUL = 9'b000000100,
		ST_HSV_FIN = 9'b000001000,
		ST_MAC     = 9'b000010000,
		ST_IDX     = 9'b000100000,
		ST_ROM     = 9'b001000000,
		ST_ROM_WR  = 9'b010000000,
		ST_OUT     = 9'b100000000
	} state_t;

	state_t                state_q;
	lace_pkg::job_t        job_q;
	lace_pkg::out_word_t   res_q;
	logic [2:0]            sector_q;
	logic [15:0]           g_q;
	logic signed [17:0]    v_q [3];
	logic [1:0]            k_q, j_q;
	logic signed [37:0]    acc_q;
	logic [35:0]           prod_q;
	logic [7:0]            rom_q;
	logic [7:0]            rgb_q [3];

	logic signed [17:0]    mul_a, mul_b;
	logic signed [35:0]    mul_p;

	// HSV sector decode
	logic [18:0]           p6, f;
	logic [2:0]            sector;
	// CIE front values
	logic [16:0]           fx, fy;
	logic signed [18:0]    fz;
	// ramp division by 65535
	logic [7:0]            q0, q;
	logic [16:0]           r;
	logic [8:0]            ramp;
	// linear channel clamp
	logic signed [37:0]    shifted;
	logic [16:0]           u;
	// finished color words
	lace_pkg::out_word_t   hsv_res, xy_res;

	assign job_pop  = (state_q == ST_IDLE) && !job_empty;
	assign res_push = (state_q == ST_OUT) && !res_full;
	assign res      = res_q;

	always_comb begin
		p6 = {1'b0, job_q.hue16, 2'b00} + {2'b00, job_q.hue16, 1'b0};
		priority if (p6 >= 19'd327675) begin
			sector = 3'd5;
			f      = p6 - 19'd327675;
		end else if (p6 >= 19'd262140) begin
			sector = 3'd4;
			f      = p6 - 19'd262140;
		end else if (p6 >= 19'd196605) begin
			sector = 3'd3;
			f      = p6 - 19'd196605;
		end else if (p6 >= 19'd131070) begin
			sector = 3'd2;
			f      = p6 - 19'd131070;
		end else if (p6 >= 19'd65535) begin
			sector = 3'd1;
			f      = p6 - 19'd65535;
		end else begin
			sector = 3'd0;
			f      = p6;
		end
	end

	always_comb begin
		fx = {1'b0, job_q.x} + {16'd0, job_q.x[15]};
		fy = {1'b0, job_q.y} + {16'd0, job_q.y[15]};
		fz = 19'sd65536 - signed'({2'b00, fx}) - signed'({2'b00, fy});
	end

	always_comb begin
		q0   = prod_q[23:16];
		r    = {1'b0, prod_q[15:0]} + {9'd0, q0};
		q    = q0 + {7'd0, (r >= 17'd65535)};
		ramp = 9'd255 - {1'b0, job_q.sat} + {1'b0, q};
	end

	always_comb begin
		shifted = acc_q >>> 15;
		if (acc_q <= 0) begin
			u = '0;
		end else if (shifted > 38'sd65536) begin
			u = lace_pkg::Q16_ONE;
		end else begin
			u = shifted[16:0];
		end
	end

	// place full, ramp and zero components by sector
	always_comb begin
		hsv_res             = '0;
		hsv_res.color_valid = 1'b1;
		unique case (sector_q)
			3'd0: begin
				hsv_res.red = 8'd255; hsv_res.green = ramp[7:0];
				hsv_res.blue = ~job_q.sat;
			end
			3'd1: begin
				hsv_res.red = ramp[7:0]; hsv_res.green = 8'd255;
				hsv_res.blue = ~job_q.sat;
			end
			3'd2: begin
				hsv_res.red = ~job_q.sat; hsv_res.green = 8'd255;
				hsv_res.blue = ramp[7:0];
			end
			3'd3: begin
				hsv_res.red = ~job_q.sat; hsv_res.green = ramp[7:0];
				hsv_res.blue = 8'd255;
			end
			3'd4: begin
				hsv_res.red = ramp[7:0]; hsv_res.green = ~job_q.sat;
				hsv_res.blue = 8'd255;
			end
			default: begin
				hsv_res.red = 8'd255; hsv_res.green = ~job_q.sat;
				hsv_res.blue = ramp[7:0];
			end
		endcase
	end

	// merge the channel just read from the ROM with those already done
	always_comb begin
		xy_res             = '0;
		xy_res.color_valid = 1'b1;
		xy_res.red         = (k_q == 2'd0) ? rom_q : rgb_q[0];
		xy_res.green       = (k_q == 2'd1) ? rom_q : rgb_q[1];
		xy_res.blue        = rom_q;
	end

	always_comb begin
		unique case (state_q)
			ST_HSV_MUL: begin
				mul_a = {10'd0, job_q.sat};
				mul_b = {2'b00, g_q};
			end
			ST_MAC: begin
				mul_a = lace_pkg::MTX[k_q][j_q];
				mul_b = v_q[j_q];
			end
			ST_IDX: begin
				mul_a = {1'b0, u};
				mul_b = 18'(ENTRIES - 1);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				job_q <= job;
			end
			ST_DECODE: begin
				sector_q <= sector;
				g_q      <= sector[0] ? 16'(19'd65535 - f) : f[15:0];
				v_q[0]   <= signed'({1'b0, fx});
				v_q[1]   <= signed'({1'b0, fy});
				v_q[2]   <= (fz < 0) ? 18'sd0 : fz[17:0];
				acc_q    <= '0;
				res_q    <= job_q.res;
			end
			ST_HSV_MUL: begin
				prod_q <= mul_p;
			end
			ST_HSV_FIN: begin
				res_q <= hsv_res;
			end
			ST_MAC: begin
				acc_q <= acc_q + 38'(mul_p);
			end
			ST_IDX: begin
				prod_q <= mul_p;
			end
			ST_ROM: begin
				rom_q <= GAMMA_ROM[prod_q[16 +: IDX_W]];
			end
			ST_ROM_WR: begin
				rgb_q[k_q] <= rom_q;
				acc_q      <= '0;
				res_q      <= xy_res;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					k_q <= '0;
					j_q <= '0;
					unique case (job_q.op)
						lace_pkg::OP_HSV: state_q <= ST_HSV_MUL;
						lace_pkg::OP_XY:  state_q <= ST_MAC;
						default:          state_q <= ST_OUT;
					endcase
				end
				ST_HSV_MUL: state_q <= ST_HSV_FIN;
				ST_HSV_FIN: state_q <= ST_OUT;
				ST_MAC: begin
					if (j_q == 2'd2) begin
						j_q     <= '0;
						state_q <= ST_IDX;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_IDX: state_q <= ST_ROM;
				ST_ROM: state_q <= ST_ROM_WR;
				ST_ROM_WR: begin
					if (k_q == 2'd2) begin
						state_q <= ST_OUT;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_MAC;
					end
				end
				ST_OUT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/light_attribute_color_engine.sv
// Light attribute color engine: attribute writes in, power, level and color commands out.
//
// Each attribute write pushed in gives exactly one result word, in order. The front part
// checks status, endpoint and type at the push, updates the stored hue, saturation and
// color x, and queues a job word (two deep). The back part pops jobs and runs them on
// one shared 18x18 multiplier: power, level, rejected and ignored writes go straight to
// the output state, HSV colors take a single multiply, and CIE xy colors run, per channel,
// one matrix row of three multiply-accumulates, then a gamma index multiply and a
// registered gamma ROM read. Results wait in a two-deep output queue; the front keeps accepting words
// while the job queue has room, so full rises once two jobs wait behind a busy sequencer
// (a long xy color, or a sequencer held at its output by a backed-up result queue). The
// gamma ROM is built at elaboration from GAMMA_TABLE_ENTRIES; there is no clearing pass
// after reset. The endpoint register is written through the cfg channel, which is always
// ready.
module light_attribute_color_engine #(
	parameter int GAMMA_TABLE_ENTRIES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  lace_pkg::in_word_t  req,
	output logic                empty,
	input  logic                pop,
	output lace_pkg::out_word_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	lace_pkg::job_t      job_in, job_out;
	lace_pkg::out_word_t res;
	logic                job_full, job_empty, job_pop;
	logic                res_push, res_full;
	logic                accept;

	// take a word when the job queue has room
	assign full   = job_full;
	assign accept = push && !job_full;

	lace_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.job       (job_in)
	);

	// decouple classification from the color sequencer
	lace_fifo #(.DEPTH(2), .T(lace_pkg::job_t)) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.dout   (job_out),
		.empty  (job_empty)
	);

	lace_back #(.ENTRIES(GAMMA_TABLE_ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.res       (res),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	// hold finished results until the consumer pops them
	lace_fifo #(.DEPTH(2), .T(lace_pkg::out_word_t)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.dout   (rsp),
		.empty  (empty)
	);

endmodule

// File: rtl/lace_checker.sv
// Port-level checks of the light attribute color engine and their binding.
`include "light_attribute_color_engine_defines.svh"

module lace_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input lace_pkg::out_word_t rsp
);

	logic [2:0] kinds;
	logic       no_level_color;
	logic       fields_clear;

	assign kinds          = {rsp.power_valid, rsp.level_valid, rsp.color_valid};
	assign no_level_color = !rsp.level_valid && !rsp.color_valid;
	assign fields_clear   = rsp.brightness == 8'd0 && rsp.red == 8'd0
		&& rsp.green == 8'd0 && rsp.blue == 8'd0;

	// a rejected word carries no command
	`LACE_ASSERT_NOW(a_error_alone, !empty && rsp.error, kinds == 3'b000)
	// one kind of command per word
	`LACE_ASSERT_NOW(a_one_kind, !empty, $countones(kinds) <= 1)
	// idle fields read as zero
	`LACE_ASSERT_NOW(a_zero_fields, !empty && no_level_color, fields_clear)
	// a waiting word holds until popped
	`LACE_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(rsp))

endmodule

bind light_attribute_color_engine lace_checker u_lace_checker (.*);

// File: verif/light_attribute_color_engine_tb.sv
// Self-checking testbench for the light attribute color engine: directed and random words.
module light_attribute_color_engine_tb;

	localparam int TABLE_SIZE = 1024;
	localparam int SETTLE_CYCLES = 40;

	// Predicts each result word from the accepted attribute writes and checks the
	// words that come out against those predictions, oldest first.
	class color_scoreboard;
		lace_pkg::out_word_t expected_words[$];
		logic [7:0] endpoint_reg;
		logic [7:0] hue_reg;
		logic [7:0] sat_reg;
		logic [15:0] x_reg;
		logic [7:0] gamma_rom[TABLE_SIZE];
		int mtx[3][3];
		int mismatches;
		int checked;
		int colors_seen;

		function new();
			longint unsigned thr[256];
			int n;
			mtx = '{'{106188, -50371, -16338}, '{-31749, 61466, 1360}, '{1825, -6685, 34636}};
			endpoint_reg = lace_pkg::ENDPOINT_RESET;
			hue_reg = 8'd0;
			sat_reg = lace_pkg::SAT_RESET;
			x_reg = 16'd0;
			mismatches = 0;
			checked = 0;
			colors_seen = 0;
			for (int c = 1; c < 256; c++)
				thr[c] = decode_level(c) * longint'(TABLE_SIZE - 1);
			for (int i = 0; i < TABLE_SIZE; i++) begin
				n = 0;
				for (int c = 1; c < 256; c++)
					if (thr[c] <= (longint'(i) << 30))
						n++;
				gamma_rom[i] = n[7:0];
			end
		endfunction

		// Largest Q30 r whose truncated fifth power stays at or below v.
		function longint unsigned root5(longint unsigned v);
			longint unsigned lo, hi, mid, p;
			lo = 0;
			hi = 64'd1 << 30;
			while (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				p = mid;
				for (int k = 0; k < 4; k++)
					p = (p * mid) >> 30;
				if (p <= v)
					lo = mid;
				else
					hi = mid - 1;
			end
			return lo;
		endfunction

		// Linear value of an sRGB code, Q30.
		function longint unsigned decode_level(int c);
			longint unsigned t, t2;
			if (c <= 10)
				return ((longint'(c) * 100) << 30) / 329460;
			t = ((longint'(c) * 1000 + 14025) << 30) / 269025;
			t2 = (t * t) >> 30;
			return (t2 * root5(t2)) >> 30;
		endfunction

		function void hsv_rgb(logic [15:0] hue16, logic [7:0] sat,
			ref lace_pkg::out_word_t w);
			int unsigned p, sector, f, g, full_c, zero_c, ramp_c;
			p = hue16 * 6;
			sector = p / 65535;
			if (sector > 5)
				sector = 5;
			f = p - sector * 65535;
			g = sector[0] ? 65535 - f : f;
			full_c = 255;
			zero_c = 255 - sat;
			ramp_c = 255 - sat + (sat * g) / 65535;
			case (sector)
				0: {w.red, w.green, w.blue} = {full_c[7:0], ramp_c[7:0], zero_c[7:0]};
				1: {w.red, w.green, w.blue} = {ramp_c[7:0], full_c[7:0], zero_c[7:0]};
				2: {w.red, w.green, w.blue} = {zero_c[7:0], full_c[7:0], ramp_c[7:0]};
				3: {w.red, w.green, w.blue} = {zero_c[7:0], ramp_c[7:0], full_c[7:0]};
				4: {w.red, w.green, w.blue} = {ramp_c[7:0], zero_c[7:0], full_c[7:0]};
				default: {w.red, w.green, w.blue} = {full_c[7:0], zero_c[7:0], ramp_c[7:0]};
			endcase
			w.color_valid = 1'b1;
		endfunction

		function void xy_rgb(logic [15:0] x, logic [15:0] y, ref lace_pkg::out_word_t w);
			longint v[3];
			longint s, u, idx;
			logic [7:0] ch[3];
			v[0] = (longint'(x) * 65536 + 32767) / 65535;
			v[1] = (longint'(y) * 65536 + 32767) / 65535;
			v[2] = 65536 - v[0] - v[1];
			if (v[2] < 0)
				v[2] = 0;
			for (int k = 0; k < 3; k++) begin
				s = mtx[k][0] * v[0] + mtx[k][1] * v[1] + mtx[k][2] * v[2];
				u = 0;
				if (s > 0) begin
					u = s >>> 15;
					if (u > 65536)
						u = 65536;
				end
				idx = (u * (TABLE_SIZE - 1)) >> 16;
				if (idx > TABLE_SIZE - 1)
					idx = TABLE_SIZE - 1;
				ch[k] = gamma_rom[idx];
			end
			{w.red, w.green, w.blue} = {ch[0], ch[1], ch[2]};
			w.color_valid = 1'b1;
		endfunction

		// Note an accepted write: update the stored color state and queue its result.
		function void note_write(lace_pkg::in_word_t r);
			lace_pkg::out_word_t w;
			w = '0;
			if (!r.status_ok)
				w.error = 1'b1;
			else if (r.endpoint == endpoint_reg && r.type_ok) begin
				case (r.command)
					lace_pkg::CMD_ONOFF: begin
						w.power_valid = 1'b1;
						w.power_on = r.value_present & r.attr_value[0];
					end
					lace_pkg::CMD_LEVEL: begin
						w.level_valid = 1'b1;
						w.brightness = r.value_present ? r.attr_value[7:0] : 8'd255;
					end
					lace_pkg::CMD_HUE: begin
						hue_reg = r.value_present ? r.attr_value[7:0] : 8'd0;
						hsv_rgb(hue_reg * 16'd257, sat_reg, w);
					end
					lace_pkg::CMD_SAT: begin
						sat_reg = r.value_present ? r.attr_value[7:0] : 8'd255;
						hsv_rgb(hue_reg * 16'd257, sat_reg, w);
					end
					lace_pkg::CMD_X: x_reg = r.value_present ? r.attr_value : 16'd0;
					lace_pkg::CMD_Y:
						xy_rgb(x_reg, r.value_present ? r.attr_value : 16'd0, w);
					lace_pkg::CMD_EHUE:
						hsv_rgb(r.value_present ? r.attr_value : 16'd0, sat_reg, w);
					default: ;
				endcase
			end
			expected_words.push_back(w);
		endfunction

		function void check_word(lace_pkg::out_word_t got);
			lace_pkg::out_word_t want;
			checked++;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %p", got);
				return;
			end
			want = expected_words.pop_front();
			if (want.color_valid)
				colors_seen++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d mismatch: expected %p, got %p", checked, want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	lace_pkg::in_word_t req = '0;
	logic empty;
	logic pop = 1'b0;
	lace_pkg::out_word_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = 8'd0;

	color_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int writes_sent = 0;

	light_attribute_color_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.empty(empty),
		.pop(pop),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#4000000;
		$display("[light_attribute_color_engine] ERROR");
		$finish;
	end

	// Drain side: pop at random, or hold off entirely while hold_cycles runs down.
	initial begin
		sb = new();
		forever begin
			if (hold_cycles > 0) begin
				hold_cycles--;
				pop <= 1'b0;
			end else
				pop <= ($urandom_range(99) >= recv_stall_pct);
			@(posedge clk);
			if (arst_n && pop && !empty)
				sb.check_word(rsp);
		end
	end

	function automatic lace_pkg::in_word_t make_word(logic [2:0] cmd, logic [15:0] val,
		logic pres, logic [7:0] ep, logic st, logic ty);
		lace_pkg::in_word_t w;
		w.command = cmd;
		w.attr_value = val;
		w.value_present = pres;
		w.endpoint = ep;
		w.status_ok = st;
		w.type_ok = ty;
		return w;
	endfunction

	// Offer one word, after a random idle gap, and hold it until the block takes it.
	task automatic send_write(lace_pkg::in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req <= w;
		do
			@(posedge clk);
		while (full);
		sb.note_write(w);
		writes_sent++;
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_endpoint(logic [7:0] ep);
		cfg_valid <= 1'b1;
		cfg_data <= ep;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.endpoint_reg = ep;
		@(posedge clk);
	endtask

	// Mostly well-formed writes to this light, with some rejected or stray ones mixed in.
	task automatic send_random(int count);
		logic [7:0] ep;
		logic [2:0] cmd;
		for (int i = 0; i < count; i++) begin
			ep = ($urandom_range(9) == 0) ? 8'($urandom) : sb.endpoint_reg;
			if ($urandom_range(3) == 0) begin
				// color x followed by color y, the pairing that yields an xy color
				send_write(make_word(lace_pkg::CMD_X, 16'($urandom), $urandom_range(15) != 0,
					ep, 1'b1, 1'b1));
				cmd = lace_pkg::CMD_Y;
			end else
				cmd = 3'($urandom);
			send_write(make_word(cmd, 16'($urandom), $urandom_range(9) != 0, ep,
				$urandom_range(11) != 0, $urandom_range(11) != 0));
		end
	endtask

	initial begin
		logic [7:0] phase_ep[4];
		int idle_set[4][2];
		phase_ep = '{8'd0, 8'd255, 8'($urandom), 8'd10};
		idle_set = '{'{0, 0}, '{67, 0}, '{0, 67}, '{38, 38}};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, every command, defaults and the rejection paths.
		send_write(make_word(lace_pkg::CMD_ONOFF, 16'h0001, 1'b1, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_ONOFF, 16'hFFFE, 1'b1, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_ONOFF, 16'hFFFF, 1'b0, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_LEVEL, 16'h0000, 1'b1, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_LEVEL, 16'h00FF, 1'b1, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_LEVEL, 16'h1234, 1'b0, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_HUE, 16'h00FF, 1'b1, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_SAT, 16'h0000, 1'b1, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_SAT, 16'h0080, 1'b1, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_HUE, 16'h0055, 1'b0, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_SAT, 16'h0011, 1'b0, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_EHUE, 16'hFFFF, 1'b1, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_EHUE, 16'h2AAA, 1'b1, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_EHUE, 16'h9999, 1'b0, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_X, 16'hFFFF, 1'b1, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_Y, 16'hFFFF, 1'b1, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_Y, 16'h5555, 1'b0, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_X, 16'h7777, 1'b0, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_Y, 16'h0000, 1'b1, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_X, 16'h5000, 1'b1, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_Y, 16'h5400, 1'b1, 8'd10, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_LEVEL, 16'h0042, 1'b1, 8'd10, 1'b0, 1'b1));
		send_write(make_word(lace_pkg::CMD_LEVEL, 16'h0042, 1'b1, 8'd11, 1'b1, 1'b1));
		send_write(make_word(lace_pkg::CMD_HUE, 16'h0042, 1'b1, 8'd10, 1'b1, 1'b0));
		send_write(make_word(lace_pkg::CMD_OTHER, 16'hFFFF, 1'b1, 8'd10, 1'b1, 1'b1));

		// Random phases, each with its own endpoint and idling mix.
		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			write_endpoint(phase_ep[ph]);
			send_idle_pct = idle_set[ph][0];
			recv_stall_pct = idle_set[ph][1];
			send_random(130);
			if (ph == 0)
				hold_cycles = 300; // stall the drain so the block backs up and blocks pushes
			if (ph == 2)
				wait_idle(); // pause the feed until every result is out
			send_random(130);
		end
		wait_idle();

		$display("sent %0d attribute writes over four endpoints, %0d results checked, %0d colors",
			writes_sent, sb.checked, sb.colors_seen);
		if (sb.mismatches == 0 && sb.expected_words.size() == 0)
			$display("[light_attribute_color_engine] OK");
		else
			$display("[light_attribute_color_engine] ERROR");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/lace_pkg.sv
rtl/lace_fifo.sv
rtl/lace_front.sv
rtl/lace_back.sv
rtl/light_attribute_color_engine.sv
rtl/lace_checker.sv
verif/light_attribute_color_engine_tb.sv
